FILE: sv/ntt8_pkg.sv
// Package for the 8-point NTT modulo 12289: field types, modulus, Montgomery
// constant, twiddles and the butterfly pairing of each stage.
// No dependencies.
package ntt8_pkg;

  typedef logic [13:0] coef_t;

  localparam int unsigned NPTS       = 8;
  localparam int unsigned NBF        = 4;   // butterflies per stage
  localparam int unsigned NTT_STAGES = 3;
  localparam int unsigned BF_DEPTH   = 4;   // register stages per butterfly stage
  localparam int unsigned LAT        = 1 + NTT_STAGES * BF_DEPTH;

  localparam coef_t       MOD_Q    = 14'd12289;
  localparam logic [15:0] MOD_QINV = 16'd12287;

  localparam coef_t TW_S1  = 14'd7888;
  localparam coef_t TW_S2A = 14'd11060;
  localparam coef_t TW_S2B = 14'd11208;
  localparam coef_t TW_S3A = 14'd6960;
  localparam coef_t TW_S3B = 14'd4342;
  localparam coef_t TW_S3C = 14'd6275;
  localparam coef_t TW_S3D = 14'd9759;

  // Index of the upper (u) lane of butterfly k in stage s
  function automatic int unsigned bf_lo(int unsigned s, int unsigned k);
    int unsigned lo;
    case (s)
      0:       lo = k;
      1:       lo = (k < 2) ? k : k + 2;
      default: lo = 2 * k;
    endcase
    return lo;
  endfunction

  // Index of the lower (twiddled) lane
  function automatic int unsigned bf_hi(int unsigned s, int unsigned k);
    int unsigned hi;
    case (s)
      0:       hi = k + 4;
      1:       hi = bf_lo(s, k) + 2;
      default: hi = bf_lo(s, k) + 1;
    endcase
    return hi;
  endfunction

  function automatic coef_t bf_tw(int unsigned s, int unsigned k);
    coef_t tw;
    case (s)
      0:       tw = TW_S1;
      1:       tw = (k < 2) ? TW_S2A : TW_S2B;
      default: begin
        case (k)
          0:       tw = TW_S3A;
          1:       tw = TW_S3B;
          2:       tw = TW_S3C;
          default: tw = TW_S3D;
        endcase
      end
    endcase
    return tw;
  endfunction

endpackage

FILE: sv/ntt8_montgomery_mod12289.sv
// Top level of the 8-point NTT modulo 12289 with Montgomery butterflies.
// Depends on ntt8_pkg (types, constants, stage pairing).
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+------------------------------
//  input   | in_coef_0 .. in_coef_7                 | transfer when start && !busy
//  result  | out_res_0 .. out_res_7, out_range_error| one-cycle strobe out_valid
//
// The pipeline holds one input register, then four registers per butterfly
// stage (product, Montgomery factor, reduction, add/subtract) for three stages.
// A new block is taken every cycle; busy stays low, as the pipeline never waits.
// Reset (synchronous, rst_n low) clears only the valid chain; data in flight is
// dropped. The receiver cannot stall, so results leave on their strobe.
module ntt8_montgomery_mod12289
  import ntt8_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  coef_t in_coef_0,
  input  coef_t in_coef_1,
  input  coef_t in_coef_2,
  input  coef_t in_coef_3,
  input  coef_t in_coef_4,
  input  coef_t in_coef_5,
  input  coef_t in_coef_6,
  input  coef_t in_coef_7,
  output logic  out_valid,
  output coef_t out_res_0,
  output coef_t out_res_1,
  output coef_t out_res_2,
  output coef_t out_res_3,
  output coef_t out_res_4,
  output coef_t out_res_5,
  output coef_t out_res_6,
  output coef_t out_res_7,
  output logic  out_range_error
);

  coef_t          coef_in [NPTS];
  logic           bad_in;
  logic [LAT-1:0] vld_r, vld_nxt;
  logic [LAT-1:0] err_r, err_nxt;
  // vec_r[0] is the input register, vec_r[s+1] the output of butterfly stage s
  coef_t          vec_r [NTT_STAGES+1][NPTS];

  assign busy = 1'b0;

  assign coef_in[0] = in_coef_0;
  assign coef_in[1] = in_coef_1;
  assign coef_in[2] = in_coef_2;
  assign coef_in[3] = in_coef_3;
  assign coef_in[4] = in_coef_4;
  assign coef_in[5] = in_coef_5;
  assign coef_in[6] = in_coef_6;
  assign coef_in[7] = in_coef_7;

  always_comb begin
    bad_in = 1'b0;
    for (int i = 0; i < NPTS; i++) begin
      if (coef_in[i] >= MOD_Q) bad_in = 1'b1;
    end
  end

  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};
  assign err_nxt = {err_r[LAT-2:0], bad_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // An all-zero block transforms to zeros, so zero the lanes of a bad block
  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    for (int i = 0; i < NPTS; i++) begin
      vec_r[0][i] <= bad_in ? '0 : coef_in[i];
    end
  end

  for (genvar s = 0; s < NTT_STAGES; s++) begin : g_stage
    for (genvar k = 0; k < NBF; k++) begin : g_bf
      localparam int unsigned LO = bf_lo(s, k);
      localparam int unsigned HI = bf_hi(s, k);
      localparam coef_t       TW = bf_tw(s, k);

      coef_t       u1_r, u2_r, u3_r;
      logic [27:0] z1_r, z2_r;
      logic [15:0] m2_r;
      coef_t       v3_r;
      logic [31:0] m_full;
      logic [30:0] acc;
      logic [14:0] t_raw;
      coef_t       v_nxt;
      logic [14:0] sum;
      coef_t       sum_nxt, dif_nxt;

      always_comb begin
        m_full  = 32'(z1_r[15:0]) * 32'(MOD_QINV);
        acc     = 31'(z2_r) + 31'(m2_r) * 31'(MOD_Q);
        t_raw   = acc[30:16];
        v_nxt   = (t_raw >= 15'(MOD_Q)) ? 14'(t_raw - 15'(MOD_Q)) : t_raw[13:0];
        sum     = 15'(u3_r) + 15'(v3_r);
        sum_nxt = (sum >= 15'(MOD_Q)) ? 14'(sum - 15'(MOD_Q)) : sum[13:0];
        dif_nxt = (u3_r >= v3_r) ? (u3_r - v3_r) : 14'(15'(u3_r) + 15'(MOD_Q) - 15'(v3_r));
      end

      always_ff @(posedge clk) begin
        // product
        u1_r <= vec_r[s][LO];
        z1_r <= 28'(vec_r[s][HI]) * 28'(TW);
        // Montgomery factor
        u2_r <= u1_r;
        z2_r <= z1_r;
        m2_r <= m_full[15:0];
        // reduction
        u3_r <= u2_r;
        v3_r <= v_nxt;
        // butterfly
        vec_r[s+1][LO] <= sum_nxt;
        vec_r[s+1][HI] <= dif_nxt;
      end
    end
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_range_error = err_r[LAT-1];
  assign out_res_0       = vec_r[NTT_STAGES][0];
  assign out_res_1       = vec_r[NTT_STAGES][1];
  assign out_res_2       = vec_r[NTT_STAGES][2];
  assign out_res_3       = vec_r[NTT_STAGES][3];
  assign out_res_4       = vec_r[NTT_STAGES][4];
  assign out_res_5       = vec_r[NTT_STAGES][5];
  assign out_res_6       = vec_r[NTT_STAGES][6];
  assign out_res_7       = vec_r[NTT_STAGES][7];

`ifndef ASSERT_OFF
  a_strobe_follows_start : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching transfer in");

  a_error_zeroes : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      (out_res_0 == '0 && out_res_1 == '0 && out_res_2 == '0 && out_res_3 == '0 &&
       out_res_4 == '0 && out_res_5 == '0 && out_res_6 == '0 && out_res_7 == '0))
    else $error("range error with non-zero results");

  a_results_reduced : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_res_0 < MOD_Q && out_res_1 < MOD_Q && out_res_2 < MOD_Q &&
       out_res_3 < MOD_Q && out_res_4 < MOD_Q && out_res_5 < MOD_Q &&
       out_res_6 < MOD_Q && out_res_7 < MOD_Q))
    else $error("result not reduced modulo q");
`endif

endmodule
